FILE: hw/rtl/fccs_pkg.sv
// shared types, codes and constants of the cluster chain sequencer
package fccs_pkg;

    localparam int MAX_WINDOW_SECTORS_DEF = 8;
    localparam int ENTRIES_PER_SECTOR     = 128;

    localparam logic [31:0] END_OF_CHAIN    = 32'h0FFF_FFFF;
    localparam logic [31:0] FIRST_DATA_CLUS = 32'd2;

    localparam logic [7:0]  SPC_RESET = 8'd64;
    localparam logic [31:0] DRS_RESET = 32'd0;
    localparam logic [27:0] WBC_RESET = 28'd0;
    localparam logic [3:0]  WS_RESET  = 4'd8;

    // command codes on the input
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_START   = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;

    // item kinds after classification
    localparam logic [1:0] KIND_NOP     = 2'd0;
    localparam logic [1:0] KIND_LOAD    = 2'd1;
    localparam logic [1:0] KIND_START   = 2'd2;
    localparam logic [1:0] KIND_ADVANCE = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_END     = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

    typedef struct packed {
        logic [7:0]  sectors_per_cluster;
        logic [31:0] data_region_start;
        logic [27:0] window_base_cluster;
        logic [3:0]  window_sectors;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  index;
        logic [31:0] value;
    } seq_item_t;

    typedef struct packed {
        logic      valid;
        seq_item_t item;
    } queue_out_t;

endpackage

FILE: hw/rtl/fccs_regs.sv
// configuration registers behind the apb port
module fccs_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output fccs_pkg::cfg_t      cfg
);
    import fccs_pkg::*;

    localparam logic [1:0] REG_SPC = 2'd0;
    localparam logic [1:0] REG_DRS = 2'd1;
    localparam logic [1:0] REG_WBC = 2'd2;
    localparam logic [1:0] REG_WS  = 2'd3;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_SPC: cfg_next.sectors_per_cluster = pwdata[7:0];
                REG_DRS: cfg_next.data_region_start   = pwdata;
                REG_WBC: cfg_next.window_base_cluster = pwdata[27:0];
                REG_WS:  cfg_next.window_sectors      = pwdata[3:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SPC: prdata = {24'd0, cfg_reg.sectors_per_cluster};
            REG_DRS: prdata = cfg_reg.data_region_start;
            REG_WBC: prdata = {4'd0, cfg_reg.window_base_cluster};
            REG_WS:  prdata = {28'd0, cfg_reg.window_sectors};
            default: prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sectors_per_cluster <= SPC_RESET;
            cfg_reg.data_region_start   <= DRS_RESET;
            cfg_reg.window_base_cluster <= WBC_RESET;
            cfg_reg.window_sectors      <= WS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hw/rtl/fccs_front.sv
// front end: takes commands, classifies them and queues them for the back end
module fccs_front
#(
    parameter int MAX_WINDOW_SECTORS = fccs_pkg::MAX_WINDOW_SECTORS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [1:0]              cmd,
    input  logic [9:0]              entry_index,
    input  logic [31:0]             entry_value,
    output logic                    busy,
    output fccs_pkg::queue_out_t    q_out,
    input  logic                    q_pop
);
    import fccs_pkg::*;

    localparam int DEPTH = MAX_WINDOW_SECTORS * ENTRIES_PER_SECTOR;

    seq_item_t  slot_reg [2];
    seq_item_t  in_item;
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;

    // loads past the end of the store are dropped to a nop
    always_comb
    begin
        in_item.index = entry_index;
        in_item.value = entry_value;
        unique case (cmd)
            CMD_LOAD:
                in_item.kind = (32'(entry_index) < 32'(DEPTH)) ? KIND_LOAD : KIND_NOP;
            CMD_START:   in_item.kind = KIND_START;
            CMD_ADVANCE: in_item.kind = KIND_ADVANCE;
            default:     in_item.kind = KIND_NOP;
        endcase
    end

    assign busy        = (count_reg == 2'd2);
    assign push        = start && !busy;
    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: hw/rtl/fccs_back.sv
// back end: fat window store, chain walk and sector address arithmetic
module fccs_back
#(
    parameter int MAX_WINDOW_SECTORS = fccs_pkg::MAX_WINDOW_SECTORS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  fccs_pkg::cfg_t          cfg,
    input  fccs_pkg::queue_out_t    q_in,
    output logic                    q_pop,
    output logic                    done,
    output logic [31:0]             sector_address,
    output logic [1:0]              status
);
    import fccs_pkg::*;

    localparam int DEPTH = MAX_WINDOW_SECTORS * ENTRIES_PER_SECTOR;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [7:0] MAX_WS = 8'(MAX_WINDOW_SECTORS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_MUL   = 2'd2;
    localparam logic [1:0] ST_ADD   = 2'd3;

    logic [31:0] fat_mem [DEPTH];

    logic [1:0]  state_reg, state_next;
    logic [31:0] cur_sector_reg, cur_sector_next;
    logic [7:0]  sic_reg, sic_next;
    logic [31:0] cur_cluster_reg, cur_cluster_next;
    logic        done_reg, done_next;
    logic [31:0] sector_address_reg, sector_address_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] addr_hold_reg, addr_hold_next;
    logic [31:0] mul_a_reg, mul_a_next;
    logic [31:0] prod_reg, prod_next;
    logic        is_start_reg, is_start_next;
    logic [31:0] rd_data_reg;

    logic        mem_we;
    logic        mem_re;
    logic [7:0]  sic_inc;
    logic [7:0]  ws_eff;
    logic [14:0] cap;
    logic [31:0] pos;
    logic        outside;
    logic [39:0] prod_full;
    logic [31:0] sum;

    assign sic_inc   = sic_reg + 8'd1;
    assign ws_eff    = ({4'd0, cfg.window_sectors} > MAX_WS) ? MAX_WS
                                                             : {4'd0, cfg.window_sectors};
    assign cap       = {ws_eff, 7'd0};
    assign pos       = cur_cluster_reg - {4'd0, cfg.window_base_cluster};
    assign outside   = (pos >= 32'(cap));
    assign prod_full = mul_a_reg * cfg.sectors_per_cluster;
    assign sum       = prod_reg + cfg.data_region_start;

    assign done           = done_reg;
    assign sector_address = sector_address_reg;
    assign status         = status_reg;

    always_comb
    begin
        state_next          = state_reg;
        cur_sector_next     = cur_sector_reg;
        sic_next            = sic_reg;
        cur_cluster_next    = cur_cluster_reg;
        done_next           = 1'b0;
        sector_address_next = sector_address_reg;
        status_next         = status_reg;
        addr_hold_next      = addr_hold_reg;
        mul_a_next          = mul_a_reg;
        prod_next           = prod_reg;
        is_start_next       = is_start_reg;
        mem_we              = 1'b0;
        mem_re              = 1'b0;
        q_pop               = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_in.valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_in.item.kind)
                        KIND_LOAD:
                        begin
                            mem_we              = 1'b1;
                            done_next           = 1'b1;
                            sector_address_next = 32'd0;
                            status_next         = STATUS_OK;
                        end
                        KIND_START:
                        begin
                            cur_cluster_next = q_in.item.value;
                            sic_next         = 8'd0;
                            mul_a_next       = q_in.item.value - FIRST_DATA_CLUS;
                            is_start_next    = 1'b1;
                            state_next       = ST_MUL;
                        end
                        KIND_ADVANCE:
                        begin
                            addr_hold_next  = cur_sector_reg;
                            cur_sector_next = cur_sector_reg + 32'd1;
                            sic_next        = sic_inc;
                            if (sic_inc == cfg.sectors_per_cluster)
                            begin
                                if (outside)
                                begin
                                    done_next           = 1'b1;
                                    sector_address_next = cur_sector_reg;
                                    status_next         = STATUS_OUTSIDE;
                                end
                                else
                                begin
                                    mem_re     = 1'b1;
                                    state_next = ST_CHECK;
                                end
                            end
                            else
                            begin
                                done_next           = 1'b1;
                                sector_address_next = cur_sector_reg;
                                status_next         = STATUS_OK;
                            end
                        end
                        default:
                        begin
                            done_next           = 1'b1;
                            sector_address_next = 32'd0;
                            status_next         = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (rd_data_reg == END_OF_CHAIN)
                begin
                    done_next           = 1'b1;
                    sector_address_next = addr_hold_reg;
                    status_next         = STATUS_END;
                    state_next          = ST_IDLE;
                end
                else
                begin
                    cur_cluster_next = rd_data_reg;
                    sic_next         = 8'd0;
                    mul_a_next       = rd_data_reg - FIRST_DATA_CLUS;
                    is_start_next    = 1'b0;
                    state_next       = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = prod_full[31:0];
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cur_sector_next     = sum;
                done_next           = 1'b1;
                sector_address_next = is_start_reg ? sum : addr_hold_reg;
                status_next         = STATUS_OK;
                state_next          = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cur_sector_reg  <= 32'd0;
            sic_reg         <= 8'd0;
            cur_cluster_reg <= 32'd0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_sector_reg  <= cur_sector_next;
            sic_reg         <= sic_next;
            cur_cluster_reg <= cur_cluster_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sector_address_reg <= sector_address_next;
        status_reg         <= status_next;
        addr_hold_reg      <= addr_hold_next;
        mul_a_reg          <= mul_a_next;
        prod_reg           <= prod_next;
        is_start_reg       <= is_start_next;
    end

    // window store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fat_mem[AW'(q_in.item.index)] <= q_in.item.value;
        end
        if (mem_re)
        begin
            rd_data_reg <= fat_mem[pos[AW-1:0]];
        end
    end

endmodule

FILE: hw/rtl/fat32_cluster_chain_sequencer.sv
// top level of the fat32 cluster chain sequencer
// path: an accepted item waits in a queue slot register; a load, an unused command and an
//   advance that stays in its cluster or falls outside the window give done from idle; end
//   of chain passes the window read and check, start the registered multiply and the add,
//   and an advance to the next cluster the window read, check, multiply and add; one item
//   per cycle while the back end is idle; busy when the two item queue is full
// reset: registers to their defaults, walk state to zero; the window store is not cleared
module fat32_cluster_chain_sequencer
#(
    parameter int MAX_WINDOW_SECTORS = fccs_pkg::MAX_WINDOW_SECTORS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [9:0]  entry_index,
    input  logic [31:0] entry_value,
    output logic        done,
    output logic [31:0] sector_address,
    output logic [1:0]  status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fccs_pkg::*;

    cfg_t       cfg;
    queue_out_t q_out;
    logic       q_pop;

    fccs_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fccs_front #(.MAX_WINDOW_SECTORS(MAX_WINDOW_SECTORS)) u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .busy        (busy),
        .q_out       (q_out),
        .q_pop       (q_pop)
    );

    fccs_back #(.MAX_WINDOW_SECTORS(MAX_WINDOW_SECTORS)) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .q_in           (q_out),
        .q_pop          (q_pop),
        .done           (done),
        .sector_address (sector_address),
        .status         (status)
    );

endmodule
